@@ sv/text_console_writer_defines.svh @@
// Assertion macros shared by the text console writer modules.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCW_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_NEVER(label, cond, msg)
`endif

`endif

@@ sv/tcw_pkg.sv @@
// Types, constants and helpers of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W      = (ROWS * COLUMNS > 1) ? $clog2(ROWS * COLUMNS) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int ADDR_W     = 20;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_ESCAPE  = 8'd38;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_ESCAPE  = 2'd1;
    localparam logic [1:0] MODE_LITERAL = 2'd2;

    localparam logic [3:0] COLOR_DEFAULT = 4'h7;

    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_PORT = 1'b1;

    localparam logic [9:0] PORT_INDEX = 10'h3D4;
    localparam logic [9:0] PORT_DATA  = 10'h3D5;
    localparam logic [7:0] CRTC_CURSOR_HI = 8'h0E;
    localparam logic [7:0] CRTC_CURSOR_LO = 8'h0F;

    localparam logic [2:0] STEP_CELL    = 3'd0;
    localparam logic [2:0] STEP_IDX_HI  = 3'd1;
    localparam logic [2:0] STEP_DATA_HI = 3'd2;
    localparam logic [2:0] STEP_IDX_LO  = 3'd3;
    localparam logic [2:0] STEP_DATA_LO = 3'd4;

    localparam logic CFG_SCREEN_BASE = 1'b0;
    localparam logic CFG_BACKGROUND  = 1'b1;

    localparam logic [ADDR_W-1:0] SCREEN_BASE_RESET = 20'd753664;
    localparam logic [3:0]        BACKGROUND_RESET  = 4'h0;

    typedef struct packed {
        logic [7:0] glyph;
        logic       end_of_text;
    } char_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] cell_address;
        logic [7:0]        cell_glyph;
        logic [7:0]        cell_attribute;
        logic [9:0]        port_number;
        logic [7:0]        port_value;
        logic              final_result;
    } result_t;

    typedef struct packed {
        logic             has_cell;
        logic             has_cursor;
        logic [POS_W-1:0] cell_pos;
        logic [7:0]       glyph;
        logic [3:0]       fg;
        logic [POS_W-1:0] cursor_pos;
    } cmd_t;

    function automatic logic [3:0] color_of(input logic [7:0] c);
        logic [3:0] col;
        case (c)
            8'h42:   col = 4'h9;
            8'h47:   col = 4'hA;
            8'h43:   col = 4'hB;
            8'h52:   col = 4'hC;
            8'h4D:   col = 4'hD;
            8'h59:   col = 4'hE;
            8'h57:   col = 4'hF;
            default: col = COLOR_DEFAULT;
        endcase
        return col;
    endfunction

endpackage

@@ sv/text_console_writer.sv @@
// Top level of the text console writer: configuration registers and wiring.
//
// Character channel (char_valid/char_stall/char_data): one character per
// transaction, with end_of_text marking the last character of a string.
// Result channel (res_valid/res_stall/res_data): cell writes (kind 0) and
// cursor port writes (kind 1); final_result marks the last result of a
// character. Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, index 0
// screen_base, index 1 background_color; cfg_ready is always high.
// Throughput: one character per cycle when it yields at most one result and
// res_stall is low; a character with end_of_text yields up to five results,
// one per cycle while res_stall is low, from the back end's step sequencer.
// A character passes the queue, cmd_reg and out_reg before its first result.
// A four-entry command queue lets characters keep coming while results wait.
// Reset: cursor 0,0, foreground 7 on background 0, normal parse mode, base
// 753664, queue and output empty. When the receiver stalls, the held result
// stays, the queue fills, then char_stall rises.
`timescale 1ns / 1ps
module text_console_writer import tcw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  char_t             char_data,
    output logic              res_valid,
    input  logic              res_stall,
    output result_t           res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data
);

    logic [ADDR_W-1:0] screen_base_reg;
    logic [3:0]        background_reg;
    logic              accept;
    logic              push;
    cmd_t              push_cmd;
    logic              full;
    logic              pop;
    logic              q_valid;
    cmd_t              q_cmd;

    assign cfg_ready  = 1'b1;
    assign char_stall = full;
    assign accept     = char_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_base_reg <= SCREEN_BASE_RESET;
            background_reg  <= BACKGROUND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCREEN_BASE: screen_base_reg <= cfg_data;
                CFG_BACKGROUND:  background_reg  <= cfg_data[3:0];
                default:         screen_base_reg <= screen_base_reg;
            endcase
        end
    end

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_data (char_data),
        .push      (push),
        .cmd       (push_cmd)
    );

    tcw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    tcw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .screen_base (screen_base_reg),
        .background  (background_reg),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data)
    );

endmodule

@@ sv/tcw_front.sv @@
// Front end: escape parsing, cursor tracking and command generation.
`timescale 1ns / 1ps
module tcw_front import tcw_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  char_t char_data,
    output logic  push,
    output cmd_t  cmd
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_base_reg, row_base_next;
    logic [3:0]       fg_reg, fg_next;
    logic [1:0]       mode_reg, mode_next;
    logic             do_put;
    logic             is_nl;
    logic             adv_row;

    always_comb
    begin
        fg_next   = fg_reg;
        mode_next = mode_reg;
        do_put    = 1'b0;
        case (mode_reg)
            MODE_ESCAPE:
            begin
                fg_next   = color_of(char_data.glyph);
                mode_next = MODE_LITERAL;
            end
            MODE_LITERAL:
            begin
                do_put    = 1'b1;
                mode_next = MODE_NORMAL;
            end
            default:
            begin
                if (char_data.glyph == CH_ESCAPE)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    do_put    = 1'b1;
                    mode_next = MODE_NORMAL;
                end
            end
        endcase
        if (char_data.end_of_text)
        begin
            mode_next = MODE_NORMAL;
        end

        is_nl   = (char_data.glyph == CH_NEWLINE);
        adv_row = 1'b0;
        col_next = col_reg;
        if (do_put)
        begin
            if (is_nl || col_reg == COL_W'(COLUMNS - 1))
            begin
                col_next = '0;
                adv_row  = 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (adv_row)
        begin
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                row_next      = '0;
                row_base_next = '0;
            end
            else
            begin
                row_next      = row_reg + 1'b1;
                row_base_next = row_base_reg + POS_W'(COLUMNS);
            end
        end

        cmd.has_cell   = do_put && !is_nl;
        cmd.has_cursor = char_data.end_of_text;
        cmd.cell_pos   = row_base_reg + POS_W'(col_reg);
        cmd.glyph      = char_data.glyph;
        cmd.fg         = fg_reg;
        cmd.cursor_pos = row_base_next + POS_W'(col_next);
        push           = accept && (cmd.has_cell || cmd.has_cursor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            row_base_reg <= '0;
            fg_reg       <= COLOR_DEFAULT;
            mode_reg     <= MODE_NORMAL;
        end
        else if (accept)
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            row_base_reg <= row_base_next;
            fg_reg       <= fg_next;
            mode_reg     <= mode_next;
        end
    end

endmodule

@@ sv/tcw_fifo.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"
module tcw_fifo import tcw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full    = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `TCW_NEVER(a_no_overflow, push && full, "push into full queue")
    `TCW_NEVER(a_no_underflow, pop && !q_valid, "pop from empty queue")
    `TCW_ASSERT(a_count_range, count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH), "queue count out of range")

endmodule

@@ sv/tcw_back.sv @@
// Back end: expands commands into cell writes and cursor port writes.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"
module tcw_back import tcw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] screen_base,
    input  logic [3:0]        background,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output result_t           res_data
);

    logic    busy_reg, busy_next;
    cmd_t    cmd_reg;
    logic [2:0] step_reg, step_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t res_next;
    logic    advance;
    logic    last;
    logic [15:0] pos16;

    assign pos16 = 16'(cmd_reg.cursor_pos);

    always_comb
    begin
        res_next = '0;
        case (step_reg)
            STEP_CELL:
            begin
                res_next.kind           = KIND_CELL;
                res_next.cell_address   = screen_base + ADDR_W'({cmd_reg.cell_pos, 1'b0});
                res_next.cell_glyph     = cmd_reg.glyph;
                res_next.cell_attribute = {background, cmd_reg.fg};
                res_next.final_result   = !cmd_reg.has_cursor;
            end
            STEP_IDX_HI:
            begin
                res_next.kind        = KIND_PORT;
                res_next.port_number = PORT_INDEX;
                res_next.port_value  = CRTC_CURSOR_HI;
            end
            STEP_DATA_HI:
            begin
                res_next.kind        = KIND_PORT;
                res_next.port_number = PORT_DATA;
                res_next.port_value  = pos16[15:8];
            end
            STEP_IDX_LO:
            begin
                res_next.kind        = KIND_PORT;
                res_next.port_number = PORT_INDEX;
                res_next.port_value  = CRTC_CURSOR_LO;
            end
            STEP_DATA_LO:
            begin
                res_next.kind         = KIND_PORT;
                res_next.port_number  = PORT_DATA;
                res_next.port_value   = pos16[7:0];
                res_next.final_result = 1'b1;
            end
            default:
            begin
                res_next.final_result = 1'b1;
            end
        endcase

        last    = res_next.final_result;
        advance = busy_reg && (!out_valid_reg || !res_stall);
        pop     = q_valid && (!busy_reg || (advance && last));

        busy_next = busy_reg;
        step_next = step_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            step_next = q_cmd.has_cell ? STEP_CELL : STEP_IDX_HI;
        end
        else if (advance)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_CELL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    `TCW_ASSERT(a_cell_no_port, res_valid && res_data.kind == KIND_CELL |-> res_data.port_number == '0 && res_data.port_value == '0, "cell write carries port fields")
    `TCW_ASSERT(a_port_final_data, res_valid && res_data.kind == KIND_PORT && res_data.final_result |-> res_data.port_number == PORT_DATA, "cursor sequence ends off data port")
    `TCW_ASSERT(a_no_stray_cell, busy_reg && !cmd_reg.has_cell |-> step_reg != STEP_CELL, "cell step without cell")
    `TCW_ASSERT(a_step_range, busy_reg |-> step_reg <= STEP_DATA_LO, "step past cursor sequence")

endmodule

@@ test/text_console_writer_test.sv @@
// Self-checking testbench of the text console writer: directed strings, random streams, stalls.
`timescale 1ns / 1ps
module text_console_writer_test;
    import tcw_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              char_valid = 1'b0;
    logic              char_stall;
    char_t             char_data = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    result_t           res_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [ADDR_W-1:0] cfg_data = '0;

    text_console_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // Console state as predicted from accepted characters
    int                cur_row = 0;
    int                cur_col = 0;
    logic [3:0]        fg_color = COLOR_DEFAULT;
    logic [1:0]        parse_mode = MODE_NORMAL;
    logic [ADDR_W-1:0] screen_base = SCREEN_BASE_RESET;
    logic [3:0]        bg_color = BACKGROUND_RESET;

    result_t pending_writes[$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_request = 0;
    int      hold_left = 0;
    string   color_letters = "BGCRMYWN";

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [3:0] letter_color(input logic [7:0] c);
        case (c)
            "B":     return 4'h9;
            "G":     return 4'hA;
            "C":     return 4'hB;
            "R":     return 4'hC;
            "M":     return 4'hD;
            "Y":     return 4'hE;
            "W":     return 4'hF;
            default: return COLOR_DEFAULT;
        endcase
    endfunction

    function automatic result_t port_write(input logic [9:0] port, input logic [7:0] value);
        result_t r;
        r = '0;
        r.kind = KIND_PORT;
        r.port_number = port;
        r.port_value = value;
        return r;
    endfunction

    task automatic advance_row();
        cur_row++;
        if (cur_row >= ROWS)
            cur_row = 0;
    endtask

    task automatic place_glyph(input logic [7:0] g, inout result_t batch[$]);
        result_t r;
        int      pos;
        if (cur_row >= ROWS)
            cur_row = 0;
        if (cur_col >= COLUMNS)
            cur_col = 0;
        if (g == CH_NEWLINE)
        begin
            cur_col = 0;
            advance_row();
        end
        else
        begin
            pos = cur_row * COLUMNS + cur_col;
            r = '0;
            r.kind = KIND_CELL;
            r.cell_address = screen_base + ADDR_W'(2 * pos);
            r.cell_glyph = g;
            r.cell_attribute = {bg_color, fg_color};
            batch.push_back(r);
            cur_col++;
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                advance_row();
            end
        end
    endtask

    task automatic predict_console_writes(input logic [7:0] g, input logic eot);
        result_t batch[$];
        int      pos;
        if (parse_mode == MODE_ESCAPE)
        begin
            fg_color = letter_color(g);
            parse_mode = MODE_LITERAL;
        end
        else if (parse_mode == MODE_LITERAL)
        begin
            parse_mode = MODE_NORMAL;
            place_glyph(g, batch);
        end
        else if (g == CH_ESCAPE)
            parse_mode = MODE_ESCAPE;
        else
        begin
            parse_mode = MODE_NORMAL;
            place_glyph(g, batch);
        end
        if (eot)
        begin
            parse_mode = MODE_NORMAL;
            if (cur_row >= ROWS)
                cur_row = 0;
            if (cur_col >= COLUMNS)
                cur_col = 0;
            pos = cur_row * COLUMNS + cur_col;
            batch.push_back(port_write(PORT_INDEX, CRTC_CURSOR_HI));
            batch.push_back(port_write(PORT_DATA, 8'((pos >> 8) & 255)));
            batch.push_back(port_write(PORT_INDEX, CRTC_CURSOR_LO));
            batch.push_back(port_write(PORT_DATA, 8'(pos & 255)));
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].final_result = 1'b1;
        foreach (batch[i])
            pending_writes.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("unexpected transaction 0x%0h", res_data));
            else
            begin
                want = pending_writes.pop_front();
                check_field("kind", 32'(res_data.kind), 32'(want.kind));
                check_field("cell_address", 32'(res_data.cell_address),
                            32'(want.cell_address));
                check_field("cell_glyph", 32'(res_data.cell_glyph), 32'(want.cell_glyph));
                check_field("cell_attribute", 32'(res_data.cell_attribute),
                            32'(want.cell_attribute));
                check_field("port_number", 32'(res_data.port_number),
                            32'(want.port_number));
                check_field("port_value", 32'(res_data.port_value), 32'(want.port_value));
                check_field("final_result", 32'(res_data.final_result),
                            32'(want.final_result));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_char(input logic [7:0] g, input logic eot);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data <= '{glyph: g, end_of_text: eot};
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        predict_console_writes(g, eot);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        char_valid <= 1'b0;
        while (pending_writes.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [ADDR_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_SCREEN_BASE)
            screen_base = value;
        else
            bg_color = value[3:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic rand_eot();
        return ($urandom_range(99) < 8);
    endfunction

    task automatic send_random_item(output int sent);
        int         pick;
        logic [7:0] letter;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            letter = ($urandom_range(9) < 7) ? color_letters[$urandom_range(7)]
                                             : 8'($urandom_range(255));
            send_char(CH_ESCAPE, rand_eot());
            send_char(letter, rand_eot());
            send_char(8'($urandom_range(255)), rand_eot());
            sent = 3;
        end
        else if (pick < 20)
        begin
            send_char(CH_NEWLINE, rand_eot());
            sent = 1;
        end
        else
        begin
            send_char(8'($urandom_range(255)), rand_eot());
            sent = 1;
        end
    endtask

    task automatic test_random_traffic(input int count);
        int total;
        int sent;
        total = 0;
        while (total < count)
        begin
            send_random_item(sent);
            total += sent;
        end
    endtask

    task automatic test_directed();
        send_char("A", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_NEWLINE, 1'b1);
        // escaped escape character is written as a cell
        send_char(CH_ESCAPE, 1'b0);
        send_char("B", 1'b0);
        send_char(CH_ESCAPE, 1'b0);
        // literal newline still moves the cursor
        send_char(CH_ESCAPE, 1'b0);
        send_char("R", 1'b0);
        send_char(CH_NEWLINE, 1'b0);
        send_char(CH_ESCAPE, 1'b0);
        send_char("G", 1'b0);
        send_char("z", 1'b1);
        // strings cut off inside an escape
        send_char(CH_ESCAPE, 1'b1);
        send_char(CH_ESCAPE, 1'b0);
        send_char("Y", 1'b1);
        send_char("q", 1'b0);
        send_char(CH_ESCAPE, 1'b0);
        send_char("W", 1'b0);
        send_char("W", 1'b0);
    endtask

    task automatic test_line_wrap();
        logic [7:0] g;
        for (int i = 0; i < 82; i++)
        begin
            g = 8'($urandom_range(255));
            if (g == CH_ESCAPE || g == CH_NEWLINE)
                g = "#";
            send_char(g, i == 81);
        end
        for (int i = 0; i < 26; i++)
            send_char(CH_NEWLINE, rand_eot());
    endtask

    task automatic test_backpressure(input int count);
        int sent;
        hold_request = 300;
        for (int i = 0; i < count; i++)
            send_random_item(sent);
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 51;
        test_directed();
        test_random_traffic(80);
        write_register(CFG_SCREEN_BASE, '0);
        write_register(CFG_BACKGROUND, 20'hF);
        test_random_traffic(60);

        send_idle_pct = 51;
        recv_idle_pct = 35;
        write_register(CFG_SCREEN_BASE, 20'd1044480);
        write_register(CFG_BACKGROUND, '0);
        test_line_wrap();
        write_register(CFG_SCREEN_BASE, 20'hFFFF0);
        write_register(CFG_BACKGROUND, 20'h9);
        test_random_traffic(50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_SCREEN_BASE, ADDR_W'($urandom_range(1044480)));
        write_register(CFG_BACKGROUND, ADDR_W'($urandom_range(15)));
        test_random_traffic(60);
        test_backpressure(50);

        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
